FILE: src/noc_route_compute_assert.svh
// Assertion macros for the route compute block.
`ifndef NOC_ROUTE_COMPUTE_ASSERT_SVH
`define NOC_ROUTE_COMPUTE_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define NRC_CHECK(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define NRC_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> cons) \
      else $error(msg);

`endif

FILE: src/nrc_pkg.sv
// Shared types, codes and defaults for the route compute block.
`default_nettype none
package nrc_pkg;

   localparam int GRID_COLS_DEFAULT = 8;
   localparam int GRID_ROWS_DEFAULT = 8;

   localparam int DEST_W  = 6;
   localparam int COORD_W = 3;
   localparam int PORT_W  = 4;
   localparam int TOPO_W  = 2;
   localparam int CSR_IDX_W = 3;

   localparam logic [TOPO_W-1:0] TOPO_MESH    = 2'd0;
   localparam logic [TOPO_W-1:0] TOPO_TORUS   = 2'd1;
   localparam logic [TOPO_W-1:0] TOPO_EXPRESS = 2'd2;

   localparam logic [PORT_W-1:0] PORT_LOCAL = 4'd0;
   localparam logic [PORT_W-1:0] PORT_N     = 4'd1;
   localparam logic [PORT_W-1:0] PORT_S     = 4'd2;
   localparam logic [PORT_W-1:0] PORT_E     = 4'd3;
   localparam logic [PORT_W-1:0] PORT_W_DIR = 4'd4;
   localparam logic [PORT_W-1:0] PORT_NX    = 4'd5;
   localparam logic [PORT_W-1:0] PORT_SX    = 4'd6;
   localparam logic [PORT_W-1:0] PORT_EX    = 4'd7;
   localparam logic [PORT_W-1:0] PORT_WX    = 4'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_TOPOLOGY  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COL  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_ROW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXP_NORTH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EXP_SOUTH = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_EXP_EAST  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_EXP_WEST  = 3'd6;

   typedef struct packed {
      logic [TOPO_W-1:0]  topology;
      logic [COORD_W-1:0] node_col;
      logic [COORD_W-1:0] node_row;
      logic [COORD_W-1:0] exp_north;
      logic [COORD_W-1:0] exp_south;
      logic [COORD_W-1:0] exp_east;
      logic [COORD_W-1:0] exp_west;
   } cfg_type;

   typedef struct packed {
      logic [DEST_W-1:0] tgt_row;
      logic [DEST_W-1:0] tgt_col;
      logic              wrap;
   } coord_type;

   typedef struct packed {
      logic [PORT_W-1:0] out_port;
      logic              is_express;
      logic              wrap_crossed;
   } route_type;

endpackage
`default_nettype wire

FILE: src/nrc_coord_split.sv
// Two-stage split of the destination id into target row and column.
`default_nettype none
module nrc_coord_split #(
   parameter int GRID_COLS = nrc_pkg::GRID_COLS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output      logic                        in_ready,
   input  wire logic [nrc_pkg::DEST_W-1:0]  in_dest,
   input  wire logic                        in_wrap,
   output      logic                        out_valid,
   input  wire logic                        out_ready,
   output      nrc_pkg::coord_type          out_coord
);
   // row = floor(dest * ceil(2^13 / cols) / 2^13), exact for dest < 64, cols <= 64
   localparam int DIV_SHIFT = 13;
   localparam int PROD_W    = nrc_pkg::DEST_W + DIV_SHIFT;
   localparam int DIV_RECIP = ((1 << DIV_SHIFT) + GRID_COLS - 1) / GRID_COLS;
   localparam int MUL_W     = 2 * nrc_pkg::DEST_W;

   logic                       s1_valid_ff, s1_valid_in;
   logic [nrc_pkg::DEST_W-1:0] s1_dest_ff, s1_dest_in;
   logic [nrc_pkg::DEST_W-1:0] s1_row_ff, s1_row_in;
   logic                       s1_wrap_ff, s1_wrap_in;
   logic                       s2_valid_ff, s2_valid_in;
   nrc_pkg::coord_type         s2_coord_ff, s2_coord_in;
   logic                       s1_ready, s2_ready;
   logic [PROD_W-1:0]          recip_prod;
   logic [MUL_W-1:0]           row_base;
   logic [MUL_W-1:0]           col_full;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   assign recip_prod = {{DIV_SHIFT{1'b0}}, in_dest} * PROD_W'(DIV_RECIP);
   assign row_base   = {{nrc_pkg::DEST_W{1'b0}}, s1_row_ff} * MUL_W'(GRID_COLS);
   assign col_full   = {{nrc_pkg::DEST_W{1'b0}}, s1_dest_ff} - row_base;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_dest_in  = s1_dest_ff;
      s1_row_in   = s1_row_ff;
      s1_wrap_in  = s1_wrap_ff;
      s2_valid_in = s2_valid_ff;
      s2_coord_in = s2_coord_ff;
      if (s1_ready) begin
         s1_valid_in = in_valid;
         s1_dest_in  = in_dest;
         s1_row_in   = recip_prod[PROD_W-1:DIV_SHIFT];
         s1_wrap_in  = in_wrap;
      end
      if (s2_ready) begin
         s2_valid_in         = s1_valid_ff;
         s2_coord_in.tgt_row = s1_row_ff;
         s2_coord_in.tgt_col = col_full[nrc_pkg::DEST_W-1:0];
         s2_coord_in.wrap    = s1_wrap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_dest_ff  <= s1_dest_in;
      s1_row_ff   <= s1_row_in;
      s1_wrap_ff  <= s1_wrap_in;
      s2_coord_ff <= s2_coord_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_coord = s2_coord_ff;
endmodule
`default_nettype wire

FILE: src/nrc_route_sel.sv
// Output port selection by dimension order, with result register.
`default_nettype none
module nrc_route_sel #(
   parameter int GRID_COLS = nrc_pkg::GRID_COLS_DEFAULT,
   parameter int GRID_ROWS = nrc_pkg::GRID_ROWS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire nrc_pkg::cfg_type   cfg,
   input  wire logic               in_valid,
   output      logic               in_ready,
   input  wire nrc_pkg::coord_type in_coord,
   output      logic               out_valid,
   input  wire logic               out_ready,
   output      nrc_pkg::route_type out_route
);
   localparam int CW = nrc_pkg::DEST_W + 1;
   localparam logic [CW-1:0] HALF_COLS = CW'(GRID_COLS >> 1);
   localparam logic [CW-1:0] HALF_ROWS = CW'(GRID_ROWS >> 1);
   localparam logic [CW-1:0] LAST_COL  = CW'(GRID_COLS - 1);
   localparam logic [CW-1:0] LAST_ROW  = CW'(GRID_ROWS - 1);

   logic               valid_ff, valid_in;
   nrc_pkg::route_type route_ff, route_in;
   logic [CW-1:0]      r, c, tr, tc;
   logic [CW-1:0]      ns, ss, es, ws;
   logic               row_inv, col_inv;
   logic [nrc_pkg::PORT_W-1:0] plain_port, port;
   logic               wrap;

   assign r  = CW'(cfg.node_row);
   assign c  = CW'(cfg.node_col);
   assign tr = CW'(in_coord.tgt_row);
   assign tc = CW'(in_coord.tgt_col);
   assign ns = CW'(cfg.exp_north);
   assign ss = CW'(cfg.exp_south);
   assign es = CW'(cfg.exp_east);
   assign ws = CW'(cfg.exp_west);

   assign row_inv = (tr > r) ? ((tr - r) > HALF_ROWS) : ((r - tr) > HALF_ROWS);
   assign col_inv = (tc > c) ? ((tc - c) > HALF_COLS) : ((c - tc) > HALF_COLS);

   always_comb begin
      if (r < tr)      plain_port = nrc_pkg::PORT_S;
      else if (r > tr) plain_port = nrc_pkg::PORT_N;
      else if (c < tc) plain_port = nrc_pkg::PORT_E;
      else if (c > tc) plain_port = nrc_pkg::PORT_W_DIR;
      else             plain_port = nrc_pkg::PORT_LOCAL;
   end

   always_comb begin
      port = plain_port;
      wrap = in_coord.wrap;
      case (cfg.topology)
         nrc_pkg::TOPO_EXPRESS: begin
            if (ss != '0 && (r + ss) <= tr)      port = nrc_pkg::PORT_SX;
            else if (ns != '0 && r >= (tr + ns)) port = nrc_pkg::PORT_NX;
            else if (es != '0 && (c + es) <= tc) port = nrc_pkg::PORT_EX;
            else if (ws != '0 && c >= (tc + ws)) port = nrc_pkg::PORT_WX;
            else                                 port = plain_port;
         end
         nrc_pkg::TOPO_TORUS: begin
            if (tr > r) begin
               if (row_inv) begin
                  port = nrc_pkg::PORT_N;
                  if (r == '0) wrap = 1'b1;
               end else begin
                  port = nrc_pkg::PORT_S;
               end
            end else if (tr < r) begin
               if (row_inv) begin
                  port = nrc_pkg::PORT_S;
                  if (r == LAST_ROW) wrap = 1'b1;
               end else begin
                  port = nrc_pkg::PORT_N;
               end
            end else if (tc > c) begin
               if (col_inv) begin
                  port = nrc_pkg::PORT_W_DIR;
                  if (c == '0) wrap = 1'b1;
               end else begin
                  port = nrc_pkg::PORT_E;
               end
            end else if (tc < c) begin
               if (col_inv) begin
                  port = nrc_pkg::PORT_E;
                  if (c == LAST_COL) wrap = 1'b1;
               end else begin
                  port = nrc_pkg::PORT_W_DIR;
               end
            end else begin
               port = nrc_pkg::PORT_LOCAL;
            end
         end
         default: port = plain_port;
      endcase
   end

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      route_in = route_ff;
      if (in_ready) begin
         valid_in              = in_valid;
         route_in.out_port     = port;
         route_in.is_express   = (port >= nrc_pkg::PORT_NX);
         route_in.wrap_crossed = wrap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      route_ff <= route_in;
   end

   assign out_valid = valid_ff;
   assign out_route = route_ff;
endmodule
`default_nettype wire

FILE: src/noc_route_compute.sv
// Route computation for head flits: dimension-order routing on mesh, torus, express mesh.
// A beat accepted on req passes through the divide stages and then the route-select register before it reaches rsp.
// Throughput: one beat per cycle while rsp is not stalled; two divide stages and one route-select stage.
// Stalls on rsp back up through the stage valid bits without loss.
// Reset (synchronous) empties the pipeline and clears all config registers to 0.
`default_nettype none
`include "noc_route_compute_assert.svh"
module noc_route_compute #(
   parameter int GRID_COLS = nrc_pkg::GRID_COLS_DEFAULT,
   parameter int GRID_ROWS = nrc_pkg::GRID_ROWS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output      logic                           req_tready,
   input  wire logic [7:0]                     req_tdata,  // dest_node[5:0], wrap_already_crossed[6], pad
   output      logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   output      logic [7:0]                     rsp_tdata,  // out_port[3:0], is_express[4], wrap_crossed[5], pad
   input  wire logic                           csr_we,
   input  wire logic [nrc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [nrc_pkg::COORD_W-1:0]    csr_wdata
);
   nrc_pkg::cfg_type   cfg_ff, cfg_in;
   logic               mid_valid, mid_ready;
   nrc_pkg::coord_type mid_coord;
   nrc_pkg::route_type route;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            nrc_pkg::CSR_TOPOLOGY:  cfg_in.topology  = csr_wdata[nrc_pkg::TOPO_W-1:0];
            nrc_pkg::CSR_NODE_COL:  cfg_in.node_col  = csr_wdata;
            nrc_pkg::CSR_NODE_ROW:  cfg_in.node_row  = csr_wdata;
            nrc_pkg::CSR_EXP_NORTH: cfg_in.exp_north = csr_wdata;
            nrc_pkg::CSR_EXP_SOUTH: cfg_in.exp_south = csr_wdata;
            nrc_pkg::CSR_EXP_EAST:  cfg_in.exp_east  = csr_wdata;
            nrc_pkg::CSR_EXP_WEST:  cfg_in.exp_west  = csr_wdata;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   nrc_coord_split #(
      .GRID_COLS (GRID_COLS)
   ) u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_dest   (req_tdata[nrc_pkg::DEST_W-1:0]),
      .in_wrap   (req_tdata[nrc_pkg::DEST_W]),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_coord (mid_coord)
   );

   nrc_route_sel #(
      .GRID_COLS (GRID_COLS),
      .GRID_ROWS (GRID_ROWS)
   ) u_sel (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_coord  (mid_coord),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_route (route)
   );

   assign rsp_tdata = {2'b00, route.wrap_crossed, route.is_express, route.out_port};

   `NRC_CHECK(a_express_flag, rsp_tvalid, rsp_tdata[4] == (rsp_tdata[3:0] >= nrc_pkg::PORT_NX), "is_express disagrees with out_port")
   `NRC_CHECK(a_port_range, rsp_tvalid, rsp_tdata[3:0] <= nrc_pkg::PORT_WX, "out_port out of range")
   `NRC_CHECK_NEXT(a_latency, req_tvalid && req_tready, ##2 rsp_tvalid, "accepted beat did not reach rsp")
endmodule
`default_nettype wire
